// ===== hw/rtl/lraster_pkg.sv =====
`timescale 1ns / 1ps

package lraster_pkg;

   // Coordinate width. Every coordinate, count and decision width follows from it.
   localparam int CoordBits = 6;
   // The decision value lies above -2*major and at or below 2*minor.
   localparam int DecBits = CoordBits + 3;

   typedef logic [CoordBits-1:0] coord_type;
   typedef logic signed [DecBits-1:0] dec_type;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_EMIT
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;
      logic step;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic zero_len;
      logic last;
   } status_type;

endpackage

// ===== hw/rtl/lraster_ctrl.sv =====
`timescale 1ns / 1ps

module lraster_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  lraster_pkg::status_type status,
   output lraster_pkg::cmd_type    cmd
);

   lraster_pkg::state_type state_ff;
   lraster_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lraster_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd.load  = 1'b0;
      cmd.step  = 1'b0;
      case (state_ff)
         lraster_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (!status.zero_len) begin
                  state_in = lraster_pkg::ST_EMIT;
               end
            end
         end
         lraster_pkg::ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.step = 1'b1;
               if (status.last) begin
                  state_in = lraster_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = lraster_pkg::ST_IDLE;
         end
      endcase
   end

   // A new command is never taken while a pixel is being presented.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("command accepted during pixel output");

   // A command with a nonzero length presents its first pixel next cycle.
   a_load_emits: assert property (@(posedge clock) disable iff (reset)
      cmd.load && !status.zero_len |=> rsp_valid)
      else $error("loaded line did not start emitting");

   // Transferring the last pixel frees the block for the next command.
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && status.last |=> req_ready && !rsp_valid)
      else $error("block not idle after last pixel");

   // A command with zero length produces no pixel.
   a_zero_silent: assert property (@(posedge clock) disable iff (reset)
      cmd.load && status.zero_len |=> !rsp_valid)
      else $error("zero-length line produced output");

endmodule

// ===== hw/rtl/lraster_dp.sv =====
`timescale 1ns / 1ps

module lraster_dp (
   input  logic                    clock,
   input  lraster_pkg::cmd_type    cmd,
   input  lraster_pkg::coord_type  start_x,
   input  lraster_pkg::coord_type  start_y,
   input  lraster_pkg::coord_type  end_x,
   input  lraster_pkg::coord_type  end_y,
   output lraster_pkg::coord_type  pixel_x,
   output lraster_pkg::coord_type  pixel_y,
   output lraster_pkg::status_type status
);

   localparam int CB = lraster_pkg::CoordBits;
   localparam int DB = lraster_pkg::DecBits;

   logic [CB:0] dx;
   logic [CB:0] dy;
   logic [CB:0] ndx;
   logic [CB:0] ndy;
   lraster_pkg::coord_type adx;
   lraster_pkg::coord_type ady;
   lraster_pkg::coord_type major;
   lraster_pkg::coord_type minor;
   logic x_major;
   lraster_pkg::dec_type p_init;

   lraster_pkg::coord_type cmaj_ff, cmaj_in;
   lraster_pkg::coord_type cmin_ff, cmin_in;
   lraster_pkg::dec_type   p_ff, p_in;
   lraster_pkg::dec_type   maj2_ff, maj2_in;
   lraster_pkg::dec_type   min2_ff, min2_in;
   lraster_pkg::coord_type cnt_ff, cnt_in;
   logic smaj_neg_ff, smaj_neg_in;
   logic smin_neg_ff, smin_neg_in;
   logic x_major_ff, x_major_in;

   always_comb begin
      dx      = {1'b0, end_x} - {1'b0, start_x};
      dy      = {1'b0, end_y} - {1'b0, start_y};
      ndx     = ~dx + 1'b1;
      ndy     = ~dy + 1'b1;
      adx     = dx[CB] ? ndx[CB-1:0] : dx[CB-1:0];
      ady     = dy[CB] ? ndy[CB-1:0] : dy[CB-1:0];
      x_major = adx > ady;
      major   = x_major ? adx : ady;
      minor   = x_major ? ady : adx;
      p_init  = $signed({2'b00, minor, 1'b0}) - $signed({3'b000, major});
   end

   always_comb begin
      cmaj_in     = cmaj_ff;
      cmin_in     = cmin_ff;
      p_in        = p_ff;
      maj2_in     = maj2_ff;
      min2_in     = min2_ff;
      cnt_in      = cnt_ff;
      smaj_neg_in = smaj_neg_ff;
      smin_neg_in = smin_neg_ff;
      x_major_in  = x_major_ff;
      if (cmd.load) begin
         x_major_in  = x_major;
         cmaj_in     = x_major ? start_x : start_y;
         cmin_in     = x_major ? start_y : start_x;
         smaj_neg_in = x_major ? dx[CB] : dy[CB];
         smin_neg_in = x_major ? dy[CB] : dx[CB];
         p_in        = p_init;
         maj2_in     = $signed({2'b00, major, 1'b0});
         min2_in     = $signed({2'b00, minor, 1'b0});
         cnt_in      = major;
      end else if (cmd.step) begin
         cmaj_in = smaj_neg_ff ? cmaj_ff - 1'b1 : cmaj_ff + 1'b1;
         cnt_in  = cnt_ff - 1'b1;
         if (p_ff > 0) begin
            cmin_in = smin_neg_ff ? cmin_ff - 1'b1 : cmin_ff + 1'b1;
            p_in    = p_ff - maj2_ff + min2_ff;
         end else begin
            p_in    = p_ff + min2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmaj_ff     <= cmaj_in;
      cmin_ff     <= cmin_in;
      p_ff        <= p_in;
      maj2_ff     <= maj2_in;
      min2_ff     <= min2_in;
      cnt_ff      <= cnt_in;
      smaj_neg_ff <= smaj_neg_in;
      smin_neg_ff <= smin_neg_in;
      x_major_ff  <= x_major_in;
   end

   assign pixel_x         = x_major_ff ? cmaj_ff : cmin_ff;
   assign pixel_y         = x_major_ff ? cmin_ff : cmaj_ff;
   assign status.zero_len = (major == '0);
   assign status.last     = (cnt_ff == lraster_pkg::coord_type'(1));

endmodule

// ===== hw/rtl/line_raster_major_axis_walk.sv =====
`timescale 1ns / 1ps

// Bresenham line rasterizer. A line command carries a start and an end point;
// the block returns one transfer per pixel, walking the major axis from the
// start toward the end and stopping one step short of the end coordinate, so
// the end column (or row) is never plotted. The axis with the larger delta is
// the major axis, and y is major when both deltas have equal magnitude. The
// final pixel of a line carries last_pixel; a command whose endpoints coincide
// yields no pixel at all. When a command is taken, the deltas, step directions
// and initial decision value are computed and loaded into the datapath
// registers, and then one pixel leaves per cycle while the output side is
// ready. The single stepping datapath produces one pixel per step, and the
// next command is taken only once the last pixel of the current line has
// been transferred.
module line_raster_major_axis_walk (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  lraster_pkg::coord_type req_start_x,
   input  lraster_pkg::coord_type req_start_y,
   input  lraster_pkg::coord_type req_end_x,
   input  lraster_pkg::coord_type req_end_y,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output lraster_pkg::coord_type rsp_pixel_x,
   output lraster_pkg::coord_type rsp_pixel_y,
   output logic                   rsp_last_pixel
);

   // Command and status between the sequencer and the stepping datapath.
   lraster_pkg::cmd_type    cmd;
   lraster_pkg::status_type status;

   // The sequencer owns both handshakes: it loads a command while idle and
   // advances the walk by one step each time a pixel is transferred.
   lraster_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the current major and minor coordinates, the decision
   // value and the count of pixels left; its registers drive the outputs.
   lraster_dp u_dp (
      .clock   (clock),
      .cmd     (cmd),
      .start_x (req_start_x),
      .start_y (req_start_y),
      .end_x   (req_end_x),
      .end_y   (req_end_y),
      .pixel_x (rsp_pixel_x),
      .pixel_y (rsp_pixel_y),
      .status  (status)
   );

   // The pixel on the outputs is the last one when a single pixel remains.
   assign rsp_last_pixel = status.last;

endmodule
